/* design/rmq_pkg.sv */
// Shared types and codes for the role matching queue.
package rmq_pkg;

   // Request kinds
   localparam logic [2:0] KIND_PUSH       = 3'd0;
   localparam logic [2:0] KIND_PEEK_ROLE  = 3'd1;
   localparam logic [2:0] KIND_POP_ROLE   = 3'd2;
   localparam logic [2:0] KIND_PEEK_GROUP = 3'd3;
   localparam logic [2:0] KIND_POP_GROUP  = 3'd4;

   // Response status codes
   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // Number of roles that make up a group
   localparam int NUM_ROLES = 3;

   // One queue entry
   typedef struct packed {
      logic [1:0]  role;
      logic [15:0] handle;
   } entry_type;

   // One response
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] role_handle;
      logic [15:0] defender_handle;
      logic        defender_found;
      logic [15:0] hunter_handle;
      logic        hunter_found;
      logic [15:0] bard_handle;
      logic        bard_found;
      logic [7:0]  occupancy;
   } result_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_DONE
   } state_type;

endpackage

/* design/rmq_store.sv */
// Entry memory: one write port, one read port with registered read data.
module rmq_store import rmq_pkg::*; #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rmq_engine.sv */
// Sequencer: scans the entry memory for the oldest entries per role and
// compacts it after a removal, one entry per cycle, with one role compare per slot.
module rmq_engine import rmq_pkg::*; #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int CW    = 8
) (
   input  logic          clock,
   input  logic          reset,
   // request side
   input  logic          req_fire,
   input  logic [2:0]    req_kind,
   input  logic [15:0]   req_handle,
   input  logic [1:0]    req_role,
   output logic          idle,
   // result side
   input  logic          rsp_free,
   output logic          res_load,
   output result_type    res,
   // memory port
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output entry_type     wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  entry_type     rd_data
);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          rvalid_ff, rvalid_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic [2:0]    kind_ff, kind_in;
   logic [1:0]    role_ff, role_in;
   logic          full_ff, full_in;
   logic [NUM_ROLES-1:0]         found_ff, found_in;
   logic [NUM_ROLES-1:0]         rem_ff, rem_in;
   logic [NUM_ROLES-1:0][AW-1:0] idx_ff, idx_in;
   logic [NUM_ROLES-1:0][15:0]   hdl_ff, hdl_in;

   logic          issue;
   logic          pass_end;
   logic          is_group;
   logic          is_lookup;
   logic          do_remove;
   logic          at_full;
   logic          skip;
   logic [AW-1:0] lo01, lo;

   // Read issue and end of a memory pass
   assign issue    = ((state_ff == ST_SCAN) || (state_ff == ST_MOVE)) &&
                     (rd_ptr_ff < count_ff);
   assign pass_end = (rd_ptr_ff >= count_ff) && !rvalid_ff;
   assign rd_en    = issue;
   assign rd_addr  = rd_ptr_ff[AW-1:0];

   assign is_group  = (kind_ff == KIND_PEEK_GROUP) || (kind_ff == KIND_POP_GROUP);
   assign is_lookup = (req_kind == KIND_PEEK_ROLE) || (req_kind == KIND_POP_ROLE) ||
                      (req_kind == KIND_PEEK_GROUP) || (req_kind == KIND_POP_GROUP);
   assign do_remove = ((kind_ff == KIND_POP_ROLE) && found_ff[0]) ||
                      ((kind_ff == KIND_POP_GROUP) && (&found_ff));
   assign at_full   = (count_ff == CW'(DEPTH));

   // Lowest index to be removed: compaction starts there
   assign lo01 = (idx_ff[0] < idx_ff[1]) ? idx_ff[0] : idx_ff[1];
   assign lo   = (kind_ff == KIND_POP_ROLE) ? idx_ff[0] :
                 ((lo01 < idx_ff[2]) ? lo01 : idx_ff[2]);

   // Entry coming back from memory is one of the removed ones
   assign skip = (rem_ff[0] && (ridx_ff == idx_ff[0])) ||
                 (rem_ff[1] && (ridx_ff == idx_ff[1])) ||
                 (rem_ff[2] && (ridx_ff == idx_ff[2]));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = is_lookup ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (pass_end) begin
               state_in = do_remove ? ST_MOVE : ST_DONE;
            end
         end
         ST_MOVE: begin
            if (pass_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory writes
   always_comb begin
      logic [1:0] tgt;
      logic       en;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      rvalid_in = issue;
      ridx_in   = rd_ptr_ff[AW-1:0];
      kind_in   = kind_ff;
      role_in   = role_ff;
      full_in   = full_ff;
      found_in  = found_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      hdl_in    = hdl_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = '{role: req_role, handle: req_handle};
      tgt       = 2'd0;
      en        = 1'b0;

      if (issue) begin
         rd_ptr_in = CW'(rd_ptr_ff + 1'b1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_kind;
               role_in   = req_role;
               full_in   = at_full;
               found_in  = '0;
               rem_in    = '0;
               rd_ptr_in = '0;
               if ((req_kind == KIND_PUSH) && !at_full) begin
                  wr_en    = 1'b1;
                  count_in = CW'(count_ff + 1'b1);
               end
            end
         end
         ST_SCAN: begin
            // Role compare per group slot on the entry returned this cycle
            if (rvalid_ff) begin
               for (int s = 0; s < NUM_ROLES; s++) begin
                  tgt = is_group ? 2'(s) : role_ff;
                  en  = is_group || (s == 0);
                  if (en && !found_ff[s] && (rd_data.role == tgt)) begin
                     found_in[s] = 1'b1;
                     idx_in[s]   = ridx_ff;
                     hdl_in[s]   = rd_data.handle;
                  end
               end
            end
            if (pass_end && do_remove) begin
               rd_ptr_in = CW'(lo);
               wr_ptr_in = lo;
               rem_in    = (kind_ff == KIND_POP_ROLE) ? 3'b001 : 3'b111;
            end
         end
         ST_MOVE: begin
            // Close the gap: later entries move down past removed ones
            if (rvalid_ff && !skip) begin
               wr_en     = 1'b1;
               wr_addr   = wr_ptr_ff;
               wr_data   = rd_data;
               wr_ptr_in = AW'(wr_ptr_ff + 1'b1);
            end
            if (pass_end) begin
               count_in = CW'(count_ff - CW'($countones(rem_ff)));
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Result assembly
   always_comb begin
      res           = '0;
      res.occupancy = 8'(count_ff);
      priority if (kind_ff == KIND_PUSH) begin
         res.status = full_ff ? STAT_FULL : STAT_DONE;
      end else if ((kind_ff == KIND_PEEK_ROLE) || (kind_ff == KIND_POP_ROLE)) begin
         res.status      = found_ff[0] ? STAT_DONE : STAT_MISS;
         res.role_handle = found_ff[0] ? hdl_ff[0] : 16'd0;
      end else if (is_group) begin
         res.status          = (&found_ff) ? STAT_DONE : STAT_MISS;
         res.defender_found  = found_ff[0];
         res.defender_handle = found_ff[0] ? hdl_ff[0] : 16'd0;
         res.hunter_found    = found_ff[1];
         res.hunter_handle   = found_ff[1] ? hdl_ff[1] : 16'd0;
         res.bard_found      = found_ff[2];
         res.bard_handle     = found_ff[2] ? hdl_ff[2] : 16'd0;
      end else begin
         res.status = STAT_DONE;
      end
   end

   assign idle     = (state_ff == ST_IDLE);
   assign res_load = (state_ff == ST_DONE) && rsp_free;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      ridx_ff   <= ridx_in;
      kind_ff   <= kind_in;
      role_ff   <= role_in;
      full_ff   <= full_in;
      found_ff  <= found_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      hdl_ff    <= hdl_in;
   end

endmodule

/* design/role_matching_queue_core.sv */
// Role matching queue: a shared arrival-ordered queue of handles tagged by
// role. A peek walks the stored entries one per cycle through one role
// compare per group slot; a pop that removes entries then makes a second
// walk from the first removed entry to the end, moving each later entry down
// through the write port. A request is taken only while the sequencer is idle; a
// finished response sits in an output register, so the next request can
// start while it waits to be taken. Reset needs no clearing pass: only
// entries below the count are read.
module role_matching_queue_core import rmq_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_handle,
   input  logic [1:0]  req_role,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_role_handle,
   output logic [15:0] rsp_defender_handle,
   output logic        rsp_defender_found,
   output logic [15:0] rsp_hunter_handle,
   output logic        rsp_hunter_found,
   output logic [15:0] rsp_bard_handle,
   output logic        rsp_bard_found,
   output logic [7:0]  rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          idle;
   logic          req_fire;
   logic          rsp_free;
   logic          res_load;
   result_type    res;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   assign req_ready = idle;
   assign req_fire  = req_valid && idle;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   rmq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rmq_engine #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_kind   (req_kind),
      .req_handle (req_handle),
      .req_role   (req_role),
      .idle       (idle),
      .rsp_free   (rsp_free),
      .res_load   (res_load),
      .res        (res),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // Output register
   always_comb begin
      rsp_in       = res_load ? res : rsp_ff;
      rsp_valid_in = res_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_role_handle     = rsp_ff.role_handle;
   assign rsp_defender_handle = rsp_ff.defender_handle;
   assign rsp_defender_found  = rsp_ff.defender_found;
   assign rsp_hunter_handle   = rsp_ff.hunter_handle;
   assign rsp_hunter_found    = rsp_ff.hunter_found;
   assign rsp_bard_handle     = rsp_ff.bard_handle;
   assign rsp_bard_found      = rsp_ff.bard_found;
   assign rsp_occupancy       = rsp_ff.occupancy;

endmodule

/* design/rmq_checker.sv */
// Port-level checks for the role matching queue, bound to the top level.
module rmq_checker import rmq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_kind,
   input logic [15:0] req_handle,
   input logic [1:0]  req_role,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_role_handle,
   input logic [15:0] rsp_defender_handle,
   input logic        rsp_defender_found,
   input logic [15:0] rsp_hunter_handle,
   input logic        rsp_hunter_found,
   input logic [15:0] rsp_bard_handle,
   input logic        rsp_bard_found,
   input logic [7:0]  rsp_occupancy
);

   // Nothing is pending right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An accepted request takes the sequencer out of idle, so requests are never taken back to back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken back to back");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_occupancy) && $stable(rsp_role_handle)))
      else $error("stalled response changed");

   // Role answers and group answers never mix
   a_role_or_group: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_role_handle != 16'd0)) |->
         (!rsp_defender_found && !rsp_hunter_found && !rsp_bard_found))
      else $error("role handle together with group members");

   // A refused push carries no handles
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |->
         ((rsp_role_handle == 16'd0) && !rsp_defender_found &&
          !rsp_hunter_found && !rsp_bard_found))
      else $error("refused push reports handles");

endmodule

bind role_matching_queue_core rmq_checker u_rmq_checker (.*);
